[design/mbg_pkg.sv]
// Package for the maze backtracker generator: sizes, codes and LFSR mask.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mbg_pkg;
  localparam int unsigned MaxWidthDef  = 64;
  localparam int unsigned MaxHeightDef = 64;
  localparam int unsigned StackDepthDef = 1024;
  localparam logic [31:0] LfsrMask = 32'h8020_0003;

  localparam logic [1:0] StatusGenDone = 2'd0;
  localparam logic [1:0] StatusReadOk  = 2'd1;
  localparam logic [1:0] StatusReadBad = 2'd2;

  localparam logic [0:0] RegGridWidth  = 1'b0;
  localparam logic [0:0] RegGridHeight = 1'b1;

  // Direction codes, north east south west
  localparam logic [1:0] DirN = 2'd0;
  localparam logic [1:0] DirE = 2'd1;
  localparam logic [1:0] DirS = 2'd2;
  localparam logic [1:0] DirW = 2'd3;

  // One Galois step of the right-shifting LFSR
  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    logic [31:0] n;
    n = s >> 1;
    if (s[0]) n = n ^ LfsrMask;
    return n;
  endfunction
endpackage
`default_nettype wire

[design/maze_backtracker_generator_core.sv]
// Maze backtracker generator top level: cell memory, visit stack and sequencer.
// Depends on mbg_pkg.
// A read checks its range in StRdAddr and, when in range, fetches the cell bit in StRdData before StOut.
// A generate first walls every row, then per cell shuffles its directions and pushes,
// tries each direction in turn, carves on each step down and reloads a parent on each
// backtrack; one item at a time, tready low while busy or a result is unread.
// Reset: sizes 63, LFSR one, then a pass over every row walls every cell.
`timescale 1ns / 1ps
`default_nettype none
module maze_backtracker_generator_core #(
  parameter int unsigned MAX_WIDTH   = mbg_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT  = mbg_pkg::MaxHeightDef,
  parameter int unsigned STACK_DEPTH = mbg_pkg::StackDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_addr_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // mode[0], seed[32:1], col[38:33], row[44:39], pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata    // cell_is_wall[0], status[2:1], zero pad
);
  import mbg_pkg::*;

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned TW = SW + 1;
  localparam int unsigned FW = XW + YW + 8 + 3;

  typedef enum logic [3:0] {
    StClear, StIdle, StRdAddr, StRdData, StOut, StStart, StShuf, StPush,
    StTop, StTry, StProbe, StCheck, StOpen, StCarve, StPop, StLoad
  } state_e;

  state_e state_q;
  logic [6:0] gw_q, gh_q;
  logic [31:0] lfsr_q;
  logic [TW-1:0] top_q;
  logic [YW:0] clr_q;
  logic [XW-1:0] cx_q;
  logic [YW-1:0] cy_q;
  logic [3:0][1:0] ord_q;
  logic [2:0] nxt_q;
  logic [1:0] si_q;
  logic [1:0] dir_q;
  logic [XW-1:0] nx_q;
  logic [YW-1:0] ny_q;
  logic wall_out_q;
  logic [1:0] status_q;
  logic [5:0] rcol_q, rrow_q;

  // Cell memory: one row word per address, single port, read registered
  logic [MAX_WIDTH-1:0] cells_mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] crow_q;
  logic                 cwe;
  logic [YW-1:0]        caddr;
  logic [MAX_WIDTH-1:0] cwdata;

  // Visit stack memory
  logic [FW-1:0] stk_mem [STACK_DEPTH];
  logic [FW-1:0] srd_q;
  logic          swe;
  logic [SW-1:0] saddr;
  logic [FW-1:0] swdata;

  // Effective sizes
  logic [8:0] ew, eh;
  always_comb begin
    ew = (gw_q < 7'd2) ? 9'd2 : ((9'(gw_q) > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : 9'(gw_q));
    eh = (gh_q < 7'd2) ? 9'd2 : ((9'(gh_q) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(gh_q));
  end

  // Shuffle unit: one draw and swap per cycle
  logic [31:0] lfsr_nx;
  logic [3:0][1:0] ord_sw;
  assign lfsr_nx = lfsr_step(lfsr_q);
  always_comb begin
    ord_sw = ord_q;
    ord_sw[si_q] = ord_q[lfsr_nx[1:0]];
    ord_sw[lfsr_nx[1:0]] = ord_q[si_q];
  end

  // Probe target two steps away, signed arithmetic on narrow values
  logic signed [10:0] tx, ty;
  always_comb begin
    tx = $signed({2'b0, 9'(cx_q)});
    ty = $signed({2'b0, 9'(cy_q)});
    unique case (dir_q)
      DirN: ty = ty - 11'sd2;
      DirE: tx = tx + 11'sd2;
      DirS: ty = ty + 11'sd2;
      DirW: tx = tx - 11'sd2;
      default: ;
    endcase
  end
  logic in_grid;
  assign in_grid = (tx >= 0) && (ty >= 0) && (tx < $signed({2'b0, ew})) &&
                   (ty < $signed({2'b0, eh}));

  // Wall cell between the current cell and the probed one
  logic [XW-1:0] mid_x;
  logic [YW-1:0] mid_y;
  assign mid_x = XW'((9'(cx_q) + 9'(nx_q)) >> 1);
  assign mid_y = YW'((9'(cy_q) + 9'(ny_q)) >> 1);

  logic [FW-1:0] frame_cur;
  assign frame_cur = {cx_q, cy_q, ord_q, nxt_q};

  // Memory port control
  always_comb begin
    cwe = 1'b0; caddr = cy_q; cwdata = crow_q;
    swe = 1'b0; saddr = SW'(top_q - TW'(1)); swdata = frame_cur;
    unique case (state_q) inside
      StClear, StStart: begin
        cwe = 1'b1; caddr = clr_q[YW-1:0]; cwdata = '1;
      end
      StRdAddr: caddr = YW'(rrow_q);
      StProbe:  caddr = ny_q;
      StOpen: begin
        // read the wall row, write the parent frame back
        caddr = mid_y; swe = 1'b1;
      end
      StCarve: begin
        cwe = 1'b1; caddr = mid_y; cwdata[mid_x] = 1'b0;
      end
      StPush: begin
        cwe = 1'b1; cwdata[cx_q] = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cwe) cells_mem[caddr] <= cwdata;
    crow_q <= cells_mem[caddr];
  end

  always_ff @(posedge clk_i) begin
    if (swe) stk_mem[saddr] <= swdata;
    srd_q <= stk_mem[saddr];
  end

  logic row_bit;
  assign row_bit = crow_q[XW'(rcol_q)];

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      gw_q <= 7'd63; gh_q <= 7'd63;
      lfsr_q <= 32'd1; top_q <= '0; clr_q <= '0;
      status_q <= StatusGenDone; wall_out_q <= 1'b0;
      cx_q <= '0; cy_q <= '0; ord_q <= '0; nxt_q <= '0; si_q <= '0;
      dir_q <= DirN; nx_q <= '0; ny_q <= '0; rcol_q <= '0; rrow_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegGridWidth:  gw_q <= cfg_wdata_i;
          RegGridHeight: gh_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (YW+1)'(MAX_HEIGHT - 1)) state_q <= StIdle;
        end
        StIdle: if (s_axis_tvalid) begin
          rcol_q <= s_axis_tdata[38:33];
          rrow_q <= s_axis_tdata[44:39];
          if (s_axis_tdata[0]) state_q <= StRdAddr;
          else begin
            lfsr_q <= (s_axis_tdata[32:1] == 32'd0) ? 32'd1 : s_axis_tdata[32:1];
            clr_q <= '0;
            state_q <= StStart;
          end
        end
        StRdAddr: begin
          if (9'(rcol_q) >= ew || 9'(rrow_q) >= eh) begin
            wall_out_q <= 1'b0; status_q <= StatusReadBad; state_q <= StOut;
          end else state_q <= StRdData;
        end
        StRdData: begin
          wall_out_q <= row_bit; status_q <= StatusReadOk; state_q <= StOut;
        end
        StOut: if (m_axis_tready) state_q <= StIdle;
        StStart: begin
          // wall sweep, then enter (1,1)
          clr_q <= clr_q + 1'b1;
          if (clr_q == (YW+1)'(MAX_HEIGHT - 1)) begin
            top_q <= '0; cx_q <= XW'(1); cy_q <= YW'(1);
            ord_q <= {DirW, DirS, DirE, DirN};
            si_q <= '0; nxt_q <= '0;
            state_q <= StShuf;
          end
        end
        StShuf: begin
          lfsr_q <= lfsr_nx;
          ord_q <= ord_sw;
          si_q <= si_q + 1'b1;
          if (si_q == 2'd3) state_q <= StPush;
        end
        StPush: begin
          top_q <= top_q + 1'b1;
          state_q <= StTop;
        end
        StTop: begin
          // current frame lives in registers; memory holds the parents
          if (nxt_q[2]) begin
            top_q <= top_q - 1'b1;
            if (top_q == TW'(1)) begin
              wall_out_q <= 1'b0; status_q <= StatusGenDone; state_q <= StOut;
            end else state_q <= StPop;
          end else begin
            dir_q <= ord_q[nxt_q[1:0]];
            nxt_q <= nxt_q + 1'b1;
            state_q <= StTry;
          end
        end
        StTry: begin
          if (!in_grid) state_q <= StTop;
          else begin
            nx_q <= XW'(tx); ny_q <= YW'(ty); state_q <= StProbe;
          end
        end
        StProbe: state_q <= StCheck;
        StCheck: begin
          // already open or stack full: skip this neighbour
          if (!crow_q[nx_q] || top_q >= TW'(STACK_DEPTH)) state_q <= StTop;
          else state_q <= StOpen;
        end
        StOpen: state_q <= StCarve;
        StCarve: begin
          cx_q <= nx_q; cy_q <= ny_q;
          ord_q <= {DirW, DirS, DirE, DirN};
          si_q <= '0; nxt_q <= '0;
          state_q <= StShuf;
        end
        StPop: state_q <= StLoad;
        StLoad: begin
          {cx_q, cy_q, ord_q, nxt_q} <= srd_q;
          state_q <= StTop;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {5'd0, status_q, wall_out_q};
endmodule
`default_nettype wire
